[rtl/atan2_pkg.sv]
// shared types, widths and polynomial constants for the atan2 pipeline
`default_nettype none

package atan2_pkg;

  // defaults for the top level parameters
  localparam int INPUT_BITS_DEF    = 24;
  localparam int ANGLE_FRAC_DEF    = 13;

  // fixed internal formats
  localparam int QBITS    = 15;           // ratio and coefficient fraction bits
  localparam int RATIO_W  = QBITS + 1;    // ratio 0..1.0 in Q1.15, unsigned
  localparam int ACC_W    = 18;           // horner accumulator, signed
  localparam int T_W      = 19;           // base and reflected angle, signed
  localparam int ANGLE_W  = 16;           // result field
  localparam int NCOEF    = 7;            // degree six plus constant term

  typedef logic signed [ACC_W-1:0] coef_t;

  // minimax coefficients in Q2.15, highest order first
  localparam coef_t POLY_COEF [NCOEF] = '{
    18'sd236, -18'sd1149, 18'sd2676, -18'sd4383, 18'sd6507, -18'sd10920, 18'sd32768
  };

  localparam logic signed [T_W-1:0] PI_Q15      = 19'sd102944;
  localparam logic signed [T_W-1:0] HALF_PI_Q15 = 19'sd51472;

  // quadrant and special case flags that travel beside the data
  typedef struct packed {
    logic zero;   // both inputs zero
    logic ybig;   // |y| > |x|, reflect about pi/2
    logic xneg;   // x negative, reflect about pi
    logic yneg;   // y negative, negate result
  } side_t;

endpackage

`default_nettype wire

[rtl/atan2_div.sv]
// pipelined restoring divider, one quotient bit per stage
`default_nettype none

module atan2_div #(
  parameter int INPUT_BITS = atan2_pkg::INPUT_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic [INPUT_BITS-1:0]                  in_big,
  input  wire logic [INPUT_BITS+atan2_pkg::RATIO_W-1:0] in_num,
  input  wire atan2_pkg::side_t                       in_side,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic [atan2_pkg::RATIO_W-1:0]               out_q,
  output atan2_pkg::side_t                            out_side
);
  import atan2_pkg::*;

  localparam int NSTG  = RATIO_W;
  localparam int REM_W = INPUT_BITS + RATIO_W;

  logic [REM_W-1:0]      rem_r  [1:NSTG];
  logic [INPUT_BITS-1:0] big_r  [1:NSTG];
  logic [RATIO_W-1:0]    q_r    [1:NSTG];
  side_t                 side_r [1:NSTG];
  logic                  v_r    [1:NSTG];
  logic                  en     [1:NSTG+1];

  // stall chain: a stage loads when empty or when the next one moves
  assign en[NSTG+1] = out_ready;
  assign in_ready   = en[1];

  for (genvar s = 1; s <= NSTG; s++) begin : g_stage
    localparam int B = NSTG - s;   // quotient bit settled here

    logic                  prev_v;
    logic [REM_W-1:0]      prev_rem;
    logic [INPUT_BITS-1:0] prev_big;
    logic [RATIO_W-1:0]    prev_q;
    side_t                 prev_side;
    logic [REM_W-1:0]      dsh;
    logic                  ge;
    logic [REM_W-1:0]      rem_nxt;
    logic [RATIO_W-1:0]    q_nxt;

    if (s == 1) begin : g_first
      assign prev_v    = in_valid;
      assign prev_rem  = in_num;
      assign prev_big  = in_big;
      assign prev_q    = '0;
      assign prev_side = in_side;
    end else begin : g_rest
      assign prev_v    = v_r[s-1];
      assign prev_rem  = rem_r[s-1];
      assign prev_big  = big_r[s-1];
      assign prev_q    = q_r[s-1];
      assign prev_side = side_r[s-1];
    end

    assign en[s] = !v_r[s] || en[s+1];

    // trial subtract of the divisor aligned to this bit
    always_comb begin
      dsh     = REM_W'(prev_big) << B;
      ge      = (prev_rem >= dsh);
      rem_nxt = ge ? (prev_rem - dsh) : prev_rem;
      q_nxt   = prev_q;
      q_nxt[B] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en[s]) begin
        v_r[s] <= prev_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem_r[s]  <= rem_nxt;
        big_r[s]  <= prev_big;
        q_r[s]    <= q_nxt;
        side_r[s] <= prev_side;
      end
    end
  end

  assign out_valid = v_r[NSTG];
  assign out_q     = q_r[NSTG];
  assign out_side  = side_r[NSTG];

endmodule

`default_nettype wire

[rtl/atan2_poly.sv]
// square, horner chain and final multiply giving the base angle in Q2.15
`default_nettype none

module atan2_poly (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [atan2_pkg::RATIO_W-1:0]  in_r,
  input  wire atan2_pkg::side_t               in_side,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [atan2_pkg::T_W-1:0]    out_t,
  output atan2_pkg::side_t                    out_side
);
  import atan2_pkg::*;

  // stage 1 squares, stages 2..7 run horner steps, stage 8 multiplies by r
  localparam int NSTG = NCOEF + 1;
  localparam int PW   = 2 * ACC_W - 1;
  localparam logic signed [PW-1:0] RND = PW'(1) << (QBITS - 1);

  logic [RATIO_W-1:0]   r_r    [1:NSTG-1];
  logic [RATIO_W-1:0]   r2_r   [1:NSTG-1];
  coef_t                acc_r  [2:NSTG-1];
  side_t                side_r [1:NSTG];
  logic                 v_r    [1:NSTG];
  logic                 en     [1:NSTG+1];
  logic signed [T_W-1:0] t_r;

  assign en[NSTG+1] = out_ready;
  assign in_ready   = en[1];

  for (genvar s = 1; s <= NSTG; s++) begin : g_en
    assign en[s] = !v_r[s] || en[s+1];
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 1; s <= NSTG; s++) v_r[s] <= 1'b0;
    end else begin
      if (en[1]) v_r[1] <= in_valid;
      for (int s = 2; s <= NSTG; s++) begin
        if (en[s]) v_r[s] <= v_r[s-1];
      end
    end
  end

  // square of the ratio, rounded to Q1.15
  logic [2*RATIO_W-1:0] sq;
  logic [2*RATIO_W-1:0] sq_rnd;
  logic [RATIO_W-1:0]   r2_nxt;

  always_comb begin
    sq     = in_r * in_r;
    sq_rnd = sq + (2*RATIO_W)'(RND);
    r2_nxt = RATIO_W'(sq_rnd >> QBITS);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      r_r[1]    <= in_r;
      r2_r[1]   <= r2_nxt;
      side_r[1] <= in_side;
    end
  end

  // horner steps: acc = round(acc * r2) + next coefficient
  for (genvar s = 2; s <= NSTG - 1; s++) begin : g_horner
    coef_t                 acc_in;
    logic signed [PW-1:0]  prod;
    logic signed [PW-1:0]  prod_rnd;
    coef_t                 acc_nxt;

    if (s == 2) begin : g_first
      assign acc_in = POLY_COEF[0];
    end else begin : g_rest
      assign acc_in = acc_r[s-1];
    end

    always_comb begin
      prod     = PW'(acc_in) * PW'($signed({1'b0, r2_r[s-1]}));
      prod_rnd = (prod + RND) >>> QBITS;
      acc_nxt  = coef_t'(prod_rnd[ACC_W-1:0]) + POLY_COEF[s-1];
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        acc_r[s]  <= acc_nxt;
        r_r[s]    <= r_r[s-1];
        r2_r[s]   <= r2_r[s-1];
        side_r[s] <= side_r[s-1];
      end
    end
  end

  // base angle = round(P(r2) * r)
  logic signed [PW-1:0] tprod;
  logic signed [PW-1:0] tprod_rnd;
  logic signed [T_W-1:0] t_nxt;

  always_comb begin
    tprod     = PW'(acc_r[NSTG-1]) * PW'($signed({1'b0, r_r[NSTG-1]}));
    tprod_rnd = (tprod + RND) >>> QBITS;
    t_nxt     = tprod_rnd[T_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[NSTG]) begin
      t_r          <= t_nxt;
      side_r[NSTG] <= side_r[NSTG-1];
    end
  end

  assign out_valid = v_r[NSTG];
  assign out_t     = t_r;
  assign out_side  = side_r[NSTG];

endmodule

`default_nettype wire

[rtl/atan2_polynomial_approx_top.sv]
// four-quadrant arctangent pipeline: magnitudes, divider, polynomial, quadrant fix-up
//
// Usage:
//   Input items arrive on in_tvalid / in_tready / in_tdata with y in the low
//   INPUT_BITS bits and x above it, both signed two's complement. Each item
//   gives exactly one result on out_tvalid / out_tready / out_tdata: the angle
//   atan2(y, x) in radians, signed, with ANGLE_FRACTION_BITS fraction bits.
//   Both inputs zero give angle 0.
//   From acceptance to out_tvalid an item passes the magnitude and compare
//   stage, the divider (one quotient bit per stage), the square, six horner
//   steps and final multiply, and the quadrant fix-up into the output
//   register.
//   Throughput is one item per cycle while out_tready stays high; every stage holds its own valid bit.
//   When the receiver holds out_tready low, items pile up behind the output
//   register, filling bubbles first; in_tready falls only once every stage
//   holds an item. Nothing is dropped or repeated across a stall.
//   A synchronous reset (rst_n low) empties the pipeline; no result is
//   shown afterwards until new items are accepted.
`default_nettype none

module atan2_polynomial_approx_top #(
  parameter int INPUT_BITS          = atan2_pkg::INPUT_BITS_DEF,
  parameter int ANGLE_FRACTION_BITS = atan2_pkg::ANGLE_FRAC_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // y_coord, x_coord
  input  wire logic [((2*INPUT_BITS+7)/8)*8-1:0]     in_tdata,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // angle
  output logic [atan2_pkg::ANGLE_W-1:0]              out_tdata
);
  import atan2_pkg::*;

  localparam int NUM_W = INPUT_BITS + RATIO_W;

  // front stage: magnitudes, compare, numerator with half divisor for rounding
  logic [INPUT_BITS-1:0] y_in, x_in, ay, ax, big, lesser;
  logic [NUM_W-1:0]      num_nxt;
  side_t                 side_nxt;

  always_comb begin
    y_in     = in_tdata[INPUT_BITS-1:0];
    x_in     = in_tdata[2*INPUT_BITS-1:INPUT_BITS];
    ay       = y_in[INPUT_BITS-1] ? (~y_in + 1'b1) : y_in;
    ax       = x_in[INPUT_BITS-1] ? (~x_in + 1'b1) : x_in;
    side_nxt.ybig = (ay > ax);
    big      = side_nxt.ybig ? ay : ax;
    lesser   = side_nxt.ybig ? ax : ay;
    side_nxt.zero = (big == '0);
    side_nxt.xneg = x_in[INPUT_BITS-1];
    side_nxt.yneg = y_in[INPUT_BITS-1];
    num_nxt  = (NUM_W'(lesser) << QBITS) + NUM_W'(big >> 1);
  end

  logic                  fr_v_r;
  logic [INPUT_BITS-1:0] fr_big_r;
  logic [NUM_W-1:0]      fr_num_r;
  side_t                 fr_side_r;
  logic                  div_in_ready;
  logic                  fr_en;

  assign fr_en     = !fr_v_r || div_in_ready;
  assign in_tready = fr_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_v_r <= 1'b0;
    end else if (fr_en) begin
      fr_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (fr_en) begin
      fr_big_r  <= big;
      fr_num_r  <= num_nxt;
      fr_side_r <= side_nxt;
    end
  end

  // ratio divider
  logic               div_v;
  logic               poly_in_ready;
  logic [RATIO_W-1:0] ratio;
  side_t              div_side;

  atan2_div #(
    .INPUT_BITS (INPUT_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_v_r),
    .in_ready  (div_in_ready),
    .in_big    (fr_big_r),
    .in_num    (fr_num_r),
    .in_side   (fr_side_r),
    .out_valid (div_v),
    .out_ready (poly_in_ready),
    .out_q     (ratio),
    .out_side  (div_side)
  );

  // polynomial
  logic                  poly_v;
  logic                  out_en;
  logic signed [T_W-1:0] base_t;
  side_t                 poly_side;

  atan2_poly u_poly (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (div_v),
    .in_ready  (poly_in_ready),
    .in_r      (ratio),
    .in_side   (div_side),
    .out_valid (poly_v),
    .out_ready (out_en),
    .out_t     (base_t),
    .out_side  (poly_side)
  );

  // quadrant reflection, clamp and rounding or widening to the output format
  logic signed [T_W-1:0] t_refl, t_quad;
  logic [T_W-2:0]        mag;
  logic [ANGLE_W-1:0]    mag_out;
  logic [ANGLE_W-1:0]    angle_nxt;

  always_comb begin
    t_refl = poly_side.ybig ? (HALF_PI_Q15 - base_t) : base_t;
    t_quad = poly_side.xneg ? (PI_Q15 - t_refl) : t_refl;
    mag    = t_quad[T_W-1] ? '0 : t_quad[T_W-2:0];
  end

  if (ANGLE_FRACTION_BITS < QBITS) begin : g_round
    localparam int SH = QBITS - ANGLE_FRACTION_BITS;
    logic [T_W-1:0] mag_rnd;
    always_comb begin
      mag_rnd = ({1'b0, mag} + (T_W'(1) << (SH - 1))) >> SH;
      mag_out = mag_rnd[ANGLE_W-1:0];
    end
  end else begin : g_widen
    localparam int LSH = ANGLE_FRACTION_BITS - QBITS;
    assign mag_out = mag[ANGLE_W-1:0] << LSH;
  end

  always_comb begin
    if (poly_side.zero) begin
      angle_nxt = '0;
    end else if (poly_side.yneg) begin
      angle_nxt = ~mag_out + 1'b1;
    end else begin
      angle_nxt = mag_out;
    end
  end

  // output register
  logic               out_v_r;
  logic [ANGLE_W-1:0] out_data_r;

  assign out_en = !out_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_en) begin
      out_v_r <= poly_v;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_data_r <= angle_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

[test/atan2_polynomial_approx_top_test.sv]
// self-checking testbench for the atan2 pipeline: directed and random coordinate items
`timescale 1ns / 100ps

module atan2_polynomial_approx_top_test;

  localparam int COORD_W = atan2_pkg::INPUT_BITS_DEF;
  localparam int ANGLE_W = atan2_pkg::ANGLE_W;
  localparam int FRAC_Q = atan2_pkg::QBITS;
  localparam int ANGLE_SHIFT = FRAC_Q - atan2_pkg::ANGLE_FRAC_DEF;
  localparam int DATA_W = ((2 * COORD_W + 7) / 8) * 8;
  localparam int RANDOM_ITEMS = 750;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 60;

  localparam longint HALF_PI_FIX = 51472;
  localparam longint PI_FIX = 102944;

  localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [COORD_W-1:0] COORD_ONE = 1;
  localparam logic [COORD_W-1:0] COORD_NEG_ONE = '1;

  typedef struct {
    logic [COORD_W-1:0] y_coord;
    logic [COORD_W-1:0] x_coord;
    logic [ANGLE_W-1:0] angle;
  } angle_entry_t;

  // expected angles, oldest first, predicted from accepted coordinate pairs
  class angle_scoreboard;
    angle_entry_t pending_angles[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // minimax coefficients in Q2.15, highest order first
    function longint horner_coef(int k);
      case (k)
        0: return 236;
        1: return -1149;
        2: return 2676;
        3: return -4383;
        4: return 6507;
        5: return -10920;
        default: return 32768;
      endcase
    endfunction

    // back to Q2.15, half rounded up
    function longint round_fix(longint v);
      return (v + (longint'(1) << (FRAC_Q - 1))) >>> FRAC_Q;
    endfunction

    function logic [ANGLE_W-1:0] atan2_angle(logic [COORD_W-1:0] y, logic [COORD_W-1:0] x);
      longint ay, ax, big, lesser, ratio, ratio_sq, acc, base, mag;
      logic yneg, xneg, ybig;
      yneg = y[COORD_W-1];
      xneg = x[COORD_W-1];
      ay = longint'($signed(y));
      ax = longint'($signed(x));
      if (ay < 0) ay = -ay;
      if (ax < 0) ax = -ax;
      ybig = ay > ax;
      big = ybig ? ay : ax;
      lesser = ybig ? ax : ay;
      if (big == 0) return '0;
      // ratio of the smaller to the larger magnitude, rounded to nearest
      ratio = ((lesser << FRAC_Q) + (big >>> 1)) / big;
      ratio_sq = round_fix(ratio * ratio);
      acc = horner_coef(0);
      for (int k = 1; k < 7; k++) begin
        acc = round_fix(acc * ratio_sq) + horner_coef(k);
      end
      base = round_fix(acc * ratio);
      // quadrant reflections
      if (ybig) base = HALF_PI_FIX - base;
      if (xneg) base = PI_FIX - base;
      if (base < 0) base = 0;
      mag = (base + (longint'(1) << (ANGLE_SHIFT - 1))) >>> ANGLE_SHIFT;
      if (yneg) mag = -mag;
      return mag[ANGLE_W-1:0];
    endfunction

    function void note_input(logic [DATA_W-1:0] data);
      angle_entry_t entry;
      entry.y_coord = data[COORD_W-1:0];
      entry.x_coord = data[2*COORD_W-1:COORD_W];
      entry.angle = atan2_angle(entry.y_coord, entry.x_coord);
      pending_angles.push_back(entry);
    endfunction

    function void check_result(logic [ANGLE_W-1:0] got);
      angle_entry_t entry;
      if (pending_angles.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected angle item: expected none, got %0d", $time,
                 $signed(got));
        return;
      end
      entry = pending_angles.pop_front();
      if (got !== entry.angle) begin
        mismatches++;
        $display("%0t: angle mismatch for y=%0d x=%0d: expected %0d, got %0d", $time,
                 $signed(entry.y_coord), $signed(entry.x_coord), $signed(entry.angle),
                 $signed(got));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [ANGLE_W-1:0] out_tdata;
  logic steady = 1'b0;
  int unsigned quiet_cycles = 0;
  angle_scoreboard sb;

  atan2_polynomial_approx_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver backpressure, none during the steady stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady || ($urandom_range(99) >= 37);
    end
  end

  // handshake monitors and idle counter
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        sb.note_input(in_tdata);
      end
      if (out_tvalid && out_tready) begin
        sb.check_result(out_tdata);
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // hang detection
  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // present one coordinate pair, then idle at random
  task automatic send_coord(input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] x);
    in_tdata <= DATA_W'({x, y});
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    while (!steady && $urandom_range(99) < 37) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_directed();
    send_coord('0, '0);
    send_coord(COORD_MAX, COORD_MAX);
    send_coord(COORD_MIN, COORD_MIN);
    send_coord(COORD_MIN, '0);
    send_coord('0, COORD_MIN);
    send_coord(COORD_MAX, '0);
    send_coord('0, COORD_MAX);
    send_coord(COORD_MIN, COORD_MAX);
    send_coord(COORD_MAX, COORD_MIN);
    // equal magnitudes in every quadrant
    send_coord(24'd100, 24'd100);
    send_coord(24'd100, -24'd100);
    send_coord(-24'd100, -24'd100);
    send_coord(-24'd100, 24'd100);
    send_coord(COORD_ONE, '0);
    send_coord('0, COORD_ONE);
    send_coord(COORD_NEG_ONE, '0);
    send_coord('0, COORD_NEG_ONE);
    send_coord(COORD_MAX, COORD_ONE);
    send_coord(COORD_ONE, COORD_MAX);
    send_coord(COORD_MIN, COORD_ONE);
    send_coord(COORD_NEG_ONE, COORD_MIN);
    send_coord(COORD_ONE, COORD_NEG_ONE);
    send_coord(COORD_NEG_ONE, COORD_NEG_ONE);
    send_coord(COORD_MIN + COORD_ONE, COORD_MIN);
  endtask

  function automatic logic [COORD_W-1:0] pick_extreme();
    case ($urandom_range(4))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return COORD_ONE;
      3: return COORD_NEG_ONE;
      default: return '0;
    endcase
  endfunction

  task automatic send_random(input int count);
    logic [COORD_W-1:0] yv, xv, m;
    for (int i = 0; i < count; i++) begin
      steady <= (i >= 300 && i < 420);
      m = COORD_W'($urandom);
      case ($urandom_range(7))
        // small magnitudes
        3: begin
          yv = COORD_W'($urandom_range(32) - 16);
          xv = COORD_W'($urandom_range(32) - 16);
        end
        // equal magnitudes with random signs
        4: begin
          yv = $urandom_range(1) ? -m : m;
          xv = $urandom_range(1) ? -m : m;
        end
        // ratio close to one
        5: begin
          yv = m;
          xv = m + COORD_W'($urandom_range(6) - 3);
          if ($urandom_range(1)) yv = -yv;
          if ($urandom_range(1)) xv = -xv;
        end
        // on an axis
        6: begin
          yv = $urandom_range(1) ? m : '0;
          xv = (yv == '0) ? m : '0;
        end
        7: begin
          yv = pick_extreme();
          xv = pick_extreme();
        end
        default: begin
          yv = COORD_W'($urandom);
          xv = COORD_W'($urandom);
        end
      endcase
      send_coord(yv, xv);
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_directed();
    send_random(RANDOM_ITEMS);
    in_tvalid <= 1'b0;
    steady <= 1'b0;
    // drain the pipeline, then watch for stray items
    while (sb.pending_angles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
